[sv/bat_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and constants for the block address translation unit.
// Depends on nothing; every other file of the block imports it.
package bat_pkg;

	localparam int ENTRIES_PER_SET_DEF = 4;
	localparam int QUEUE_DEPTH = 2;

	localparam int IN_DATA_W = 72;
	localparam int OUT_DATA_W = 40;

	localparam logic [31:0] SEG_MASK  = 32'hF000_0000;
	localparam logic [31:0] BEPI_MASK = 32'h0FFE_0000;
	localparam logic [31:0] BL_MASK   = 32'h0000_1FFC;
	localparam int          BL_SHIFT  = 15;
	localparam logic [31:0] PAGE_MASK = 32'h0001_F000;
	localparam logic [1:0]  PP_RW     = 2'h2;
	localparam logic [1:0]  PP_NONE   = 2'h0;

	typedef enum logic [1:0] {
		ST_GRANTED = 2'd0,
		ST_NOMATCH = 2'd1,
		ST_FAULT   = 2'd2,
		ST_WRITTEN = 2'd3
	} status_t;

	// Operation code carried in the input tuser.
	typedef enum logic {
		OP_TRANSLATE = 1'b0,
		OP_WRITE     = 1'b1
	} op_t;

	// Classification made by the front end.
	typedef enum logic [1:0] {
		K_TRANSLATE = 2'd0,
		K_STORE     = 2'd1,
		K_DROP      = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic        user_mode;
		logic        is_code;
		logic        is_write;
		logic [31:0] virtual_addr;
		logic        write_side;
		logic [1:0]  write_index;
		logic        write_lower;
		logic [31:0] write_value;
	} item_t;

endpackage

[sv/block_address_translation_unit.sv]
`timescale 1ns / 1ps
// Block address translation unit: top level joining front end, queue and back end.
// Depends on bat_pkg, bat_front, bat_queue and bat_back.
//
// Usage: items enter on the slave stream (s_tvalid/s_tready/s_tdata/s_tuser).
// s_tuser selects the operation: 0 translates virtual_addr against the data or
// instruction set chosen by is_code, 1 stores write_value into one upper or
// lower translation word. Every item produces exactly one result item on the
// master stream, in order; m_tuser carries the status (granted, no match,
// protection fault, or word written) and m_tdata the physical page address,
// the read, write and execute rights and the matching entry number.
// From acceptance an item passes the front register and a queue entry, and its
// result is then held in the back end's output register, which drives m_tvalid,
// until the receiver takes it. While m_tready stays high the unit sustains one
// item per cycle; a store is seen by the item accepted right after it because
// both pass the back end in order. When the receiver holds m_tready low, the
// result register holds, the two-entry queue and the front register fill, and
// s_tready falls once all three are occupied.
// Reset clears every translation word, so no entry is valid afterwards, and
// empties all stages.
module block_address_translation_unit #(
	parameter int ENTRIES_PER_SET = bat_pkg::ENTRIES_PER_SET_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// user_mode[0], is_code[1], is_write[2], virtual_addr[34:3], write_side[35],
	// write_index[37:36], write_lower[38], write_value[70:39], zero pad[71]
	input  logic [bat_pkg::IN_DATA_W-1:0]  s_tdata,
	// op[0]
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// phys_addr[31:0], allow_read[32], allow_write[33], allow_exec[34],
	// hit_entry[36:35], zero pad[39:37]
	output logic [bat_pkg::OUT_DATA_W-1:0] m_tdata,
	// status[1:0]
	output logic [1:0]                     m_tuser
);
	import bat_pkg::*;

	logic  push_valid;
	logic  push_ready;
	item_t push_item;
	logic  pop_valid;
	logic  pop_ready;
	item_t pop_item;

	// Front end: unpacks and classifies each accepted item.
	bat_front #(
		.ENTRIES_PER_SET(ENTRIES_PER_SET)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	// Queue decouples the front end from back-pressure at the output.
	bat_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	// Back end: owns the translation words and produces the results.
	bat_back #(
		.ENTRIES_PER_SET(ENTRIES_PER_SET)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

[sv/bat_front.sv]
`timescale 1ns / 1ps
// Front end: accepts input items, unpacks and classifies them into one register stage.
// Depends on bat_pkg.
module bat_front #(
	parameter int ENTRIES_PER_SET = bat_pkg::ENTRIES_PER_SET_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [bat_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                           s_tuser,
	output logic                           push_valid,
	input  logic                           push_ready,
	output bat_pkg::item_t                 push_item
);
	import bat_pkg::*;

	localparam logic [3:0] ENT = 4'(ENTRIES_PER_SET);

	logic  valid_s1;
	item_t item_s1;
	item_t item_d;

	assign s_tready = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item = item_s1;

	always_comb begin
		item_d.user_mode    = s_tdata[0];
		item_d.is_code      = s_tdata[1];
		item_d.is_write     = s_tdata[2];
		item_d.virtual_addr = s_tdata[34:3];
		item_d.write_side   = s_tdata[35];
		item_d.write_index  = s_tdata[37:36];
		item_d.write_lower  = s_tdata[38];
		item_d.write_value  = s_tdata[70:39];
		// A write to an entry past the end of the set is answered but not stored.
		if (op_t'(s_tuser) == OP_TRANSLATE) begin
			item_d.kind = K_TRANSLATE;
		end else if ({2'b00, s_tdata[37:36]} < ENT) begin
			item_d.kind = K_STORE;
		end else begin
			item_d.kind = K_DROP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_d;
		end
	end

endmodule

[sv/bat_queue.sv]
`timescale 1ns / 1ps
// Short FIFO of classified items between the front end and the back end.
// Depends on bat_pkg.
module bat_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  bat_pkg::item_t push_item,
	output logic           pop_valid,
	input  logic           pop_ready,
	output bat_pkg::item_t pop_item
);
	import bat_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t              mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

[sv/bat_back.sv]
`timescale 1ns / 1ps
// Back end: holds the translation words, carries out stores and translations,
// and drives the registered result channel. Depends on bat_pkg.
module bat_back #(
	parameter int ENTRIES_PER_SET = bat_pkg::ENTRIES_PER_SET_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pop_valid,
	output logic                           pop_ready,
	input  bat_pkg::item_t                 pop_item,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [bat_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic [1:0]                     m_tuser
);
	import bat_pkg::*;

	// Index 0 of the first dimension is the data set, 1 the instruction set.
	logic [31:0] upper_q [2][ENTRIES_PER_SET];
	logic [31:0] lower_q [2][ENTRIES_PER_SET];

	logic        m_valid_q;
	status_t     status_q;
	logic [31:0] phys_q;
	logic        rd_q;
	logic        wt_q;
	logic        ex_q;
	logic [1:0]  hit_q;

	status_t     status_d;
	logic [31:0] phys_d;
	logic        rd_d;
	logic        wt_d;
	logic [1:0]  hit_d;
	logic        take;

	assign pop_ready = !m_valid_q || m_tready;
	assign take      = pop_valid && pop_ready;

	assign m_tvalid = m_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {3'b000, hit_q, ex_q, wt_q, rd_q, phys_q};

	always_comb begin
		logic [31:0] up;
		logic [31:0] lo;
		logic [31:0] bl;
		logic        vld;
		logic [1:0]  pp;
		logic        rd;
		logic        wt;
		logic        ok;
		up       = '0;
		lo       = '0;
		bl       = '0;
		vld      = 1'b0;
		pp       = '0;
		rd       = 1'b0;
		wt       = 1'b0;
		ok       = 1'b0;
		status_d = ST_NOMATCH;
		phys_d   = '0;
		rd_d     = 1'b0;
		wt_d     = 1'b0;
		hit_d    = '0;
		if (pop_item.kind != K_TRANSLATE) begin
			status_d = ST_WRITTEN;
		end else begin
			// Walk from the highest entry down so the lowest match wins.
			for (int e = ENTRIES_PER_SET - 1; e >= 0; e--) begin
				up  = upper_q[pop_item.is_code][e];
				lo  = lower_q[pop_item.is_code][e];
				bl  = (up & BL_MASK) << BL_SHIFT;
				vld = pop_item.user_mode ? up[0] : up[1];
				if (((pop_item.virtual_addr & SEG_MASK) == (up & SEG_MASK)) &&
				    ((pop_item.virtual_addr & BEPI_MASK & ~bl) == (up & BEPI_MASK)) &&
				    vld) begin
					pp = lo[1:0];
					rd = (pp != PP_NONE);
					wt = (pp == PP_RW);
					ok = (pop_item.is_write && !pop_item.is_code) ? wt : rd;
					status_d = ok ? ST_GRANTED : ST_FAULT;
					phys_d   = (lo & SEG_MASK) | (pop_item.virtual_addr & BEPI_MASK & bl) |
					           (lo & BEPI_MASK) | (pop_item.virtual_addr & PAGE_MASK);
					rd_d     = rd;
					wt_d     = wt;
					hit_d    = 2'(e);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			for (int s = 0; s < 2; s++) begin
				for (int e = 0; e < ENTRIES_PER_SET; e++) begin
					upper_q[s][e] <= '0;
					lower_q[s][e] <= '0;
				end
			end
		end else begin
			if (pop_ready) begin
				m_valid_q <= pop_valid;
			end
			if (take && pop_item.kind == K_STORE) begin
				for (int s = 0; s < 2; s++) begin
					for (int e = 0; e < ENTRIES_PER_SET; e++) begin
						if (int'(pop_item.write_side) == s &&
						    int'(pop_item.write_index) == e) begin
							if (pop_item.write_lower) begin
								lower_q[s][e] <= pop_item.write_value;
							end else begin
								upper_q[s][e] <= pop_item.write_value;
							end
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			status_q <= status_d;
			phys_q   <= phys_d;
			rd_q     <= rd_d;
			wt_q     <= wt_d;
			ex_q     <= rd_d;
			hit_q    <= hit_d;
		end
	end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for block_address_translation_unit: directed and random
// translate and store items checked against an in-bench translation predictor.
// Depends on bat_pkg and the unit's RTL only.
module testbench;
	import bat_pkg::*;

	localparam int SET_ENTRIES  = ENTRIES_PER_SET_DEF;
	localparam int RANDOM_ITEMS = 1525;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int QUIET_TAIL   = 150;

	typedef struct {
		op_t         op;
		logic        user_mode;
		logic        is_code;
		logic        is_write;
		logic [31:0] virtual_addr;
		logic        write_side;
		logic [1:0]  write_index;
		logic        write_lower;
		logic [31:0] write_value;
	} access_req_t;

	typedef struct {
		access_req_t req;
		bit          wait_idle;   // hold this item back until every result is in
	} pending_t;

	typedef struct {
		status_t     status;
		logic [31:0] phys_addr;
		logic        allow_read;
		logic        allow_write;
		logic        allow_exec;
		logic [1:0]  hit_entry;
	} xlat_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [1:0]            m_tuser;

	block_address_translation_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #10 clk = ~clk;

	// Predictor copy of the translation store: [side][entry][lower].
	logic [31:0]  bat_words [2][SET_ENTRIES][2];
	// Generator's view of the upper words, used only to aim addresses at entries.
	logic [31:0]  gen_upper [2][SET_ENTRIES];

	pending_t     pending_items[$];
	xlat_result_t bat_results_due[$];
	access_req_t  cur_req;
	int           total_items;
	int           accepted_cnt = 0;
	int           received_cnt = 0;
	int           send_gap = 0;
	int           ready_gap = 0;
	int           hold_left = 0;
	int           long_holds = 0;
	int           error_count = 0;
	int           cycle_cnt = 0;

	// Applies one item to the predictor store and returns the result it must cause.
	function automatic xlat_result_t predict_bat_response(input access_req_t r);
		xlat_result_t res;
		logic [31:0]  up, lo, bl;
		logic [1:0]   pp;
		logic         valid, ok, found;
		res.status      = ST_NOMATCH;
		res.phys_addr   = '0;
		res.allow_read  = 1'b0;
		res.allow_write = 1'b0;
		res.allow_exec  = 1'b0;
		res.hit_entry   = '0;
		found = 1'b0;
		if (r.op == OP_WRITE) begin
			if (r.write_index < SET_ENTRIES)
				bat_words[r.write_side][r.write_index][r.write_lower] = r.write_value;
			res.status = ST_WRITTEN;
			return res;
		end
		for (int i = 0; i < SET_ENTRIES; i++) begin
			up = bat_words[r.is_code][i][0];
			lo = bat_words[r.is_code][i][1];
			bl = (up & BL_MASK) << BL_SHIFT;
			valid = r.user_mode ? up[0] : up[1];
			if (!found && (r.virtual_addr & SEG_MASK) == (up & SEG_MASK) &&
				    ((r.virtual_addr & BEPI_MASK) & ~bl) == (up & BEPI_MASK) && valid) begin
				found = 1'b1;
				pp = lo[1:0];
				res.allow_read  = (pp != PP_NONE);
				res.allow_write = (pp == PP_RW);
				res.allow_exec  = (pp != PP_NONE);
				// Instruction fetches need execute; data accesses need write or read.
				if (r.is_code)
					ok = res.allow_exec;
				else if (r.is_write)
					ok = res.allow_write;
				else
					ok = res.allow_read;
				res.status    = ok ? ST_GRANTED : ST_FAULT;
				res.phys_addr = (lo & SEG_MASK) | (r.virtual_addr & BEPI_MASK & bl) |
					(lo & BEPI_MASK) | (r.virtual_addr & PAGE_MASK);
				res.hit_entry = i[1:0];
			end
		end
		return res;
	endfunction

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %h actual %h", $time, what, want, got);
			error_count++;
		end
	endtask

	// Unused fields carry random bits so that every input bit but the zero pad toggles.
	task automatic queue_store_word(input logic side, input logic [1:0] idx,
			input logic lower, input logic [31:0] value, input bit wait_idle = 0);
		pending_t p;
		p.wait_idle            = wait_idle;
		p.req.op               = OP_WRITE;
		p.req.user_mode        = 1'($urandom_range(0, 1));
		p.req.is_code          = 1'($urandom_range(0, 1));
		p.req.is_write         = 1'($urandom_range(0, 1));
		p.req.virtual_addr     = $urandom;
		p.req.write_side       = side;
		p.req.write_index      = idx;
		p.req.write_lower      = lower;
		p.req.write_value      = value;
		if (!lower)
			gen_upper[side][idx] = value;
		pending_items.push_back(p);
	endtask

	task automatic queue_lookup(input logic user, input logic code, input logic wr,
			input logic [31:0] va, input bit wait_idle = 0);
		pending_t p;
		p.wait_idle            = wait_idle;
		p.req.op               = OP_TRANSLATE;
		p.req.user_mode        = user;
		p.req.is_code          = code;
		p.req.is_write         = wr;
		p.req.virtual_addr     = va;
		p.req.write_side       = 1'($urandom_range(0, 1));
		p.req.write_index      = 2'($urandom_range(0, 3));
		p.req.write_lower      = 1'($urandom_range(0, 1));
		p.req.write_value      = $urandom;
		pending_items.push_back(p);
	endtask

	// Sender: presents queued items, predicts each one as it is accepted.
	always @(posedge clk or negedge arst_n) begin
		bit sent, rx, offer;
		pending_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= 1'b0;
		end else begin
			sent  = s_tvalid && s_tready;
			rx    = m_tvalid && m_tready;
			offer = 1'b0;
			if (sent)
				bat_results_due.push_back(predict_bat_response(cur_req));
			if (!s_tvalid || sent) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_items.size() > 0 && !(pending_items[0].wait_idle &&
						accepted_cnt + sent != received_cnt + rx)) begin
					nxt     = pending_items.pop_front();
					cur_req = nxt.req;
					offer   = 1'b1;
					// Idle bursts, except in every third stretch and at the tail.
					if (accepted_cnt < total_items - QUIET_TAIL &&
						    (accepted_cnt / 200) % 3 != 2 && $urandom_range(0, 3) == 0)
						send_gap = $urandom_range(1, 4);
				end
				s_tvalid <= offer;
				s_tdata  <= {1'b0, cur_req.write_value, cur_req.write_lower,
					cur_req.write_index, cur_req.write_side, cur_req.virtual_addr,
					cur_req.is_write, cur_req.is_code, cur_req.user_mode};
				s_tuser  <= cur_req.op;
			end
			if (sent)
				accepted_cnt <= accepted_cnt + 1;
		end
	end

	// Receiver: checks each result against the oldest prediction and drives m_tready.
	always @(posedge clk or negedge arst_n) begin
		xlat_result_t want;
		bit ready;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (bat_results_due.size() == 0) begin
					$display("%0t ns: unexpected result status %h data %h", $time,
						m_tuser, m_tdata);
					error_count++;
				end else begin
					want = bat_results_due.pop_front();
					check_field("status", 32'(want.status), 32'(m_tuser));
					check_field("phys_addr", want.phys_addr, m_tdata[31:0]);
					check_field("allow_read", 32'(want.allow_read), 32'(m_tdata[32]));
					check_field("allow_write", 32'(want.allow_write), 32'(m_tdata[33]));
					check_field("allow_exec", 32'(want.allow_exec), 32'(m_tdata[34]));
					check_field("hit_entry", 32'(want.hit_entry), 32'(m_tdata[36:35]));
				end
				received_cnt <= received_cnt + 1;
			end
			ready = 1'b0;
			// Two long hold-offs let the unit fill up and stall its input.
			if (hold_left > 0) begin
				hold_left--;
			end else if (long_holds < 2 && received_cnt >= (long_holds == 0 ? 400 : 1100)) begin
				long_holds++;
				hold_left = 59;
			end else if (ready_gap > 0) begin
				ready_gap--;
			end else if (received_cnt < total_items - QUIET_TAIL &&
					(received_cnt / 200) % 3 != 1 && $urandom_range(0, 4) == 0) begin
				ready_gap = $urandom_range(0, 3);
			end else begin
				ready = 1'b1;
			end
			m_tready <= ready;
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		logic [31:0] up, bl, va;
		logic [1:0]  e;
		logic        side, user;
		int          k;
		for (int s = 0; s < 2; s++)
			for (int i = 0; i < SET_ENTRIES; i++) begin
				bat_words[s][i][0] = '0;
				bat_words[s][i][1] = '0;
				gen_upper[s][i]    = '0;
			end

		// Directed part. Empty store first: nothing may match.
		queue_lookup(0, 0, 0, 32'h0000_0000);
		queue_lookup(1, 1, 0, 32'hFFFF_FFFF);
		// Data entry 0: segment 1, 128 KB block, supervisor only, read/write.
		queue_store_word(0, 0, 0, 32'h1000_0002);
		queue_store_word(0, 0, 1, 32'h8000_0002);
		queue_lookup(0, 0, 0, 32'h1000_1234);
		queue_lookup(1, 0, 0, 32'h1000_1234);   // user without Vp misses
		queue_lookup(0, 0, 1, 32'h1001_F000);
		queue_lookup(0, 0, 0, 32'h1002_0000);   // outside the block
		// Read-only rights: a store faults, a load passes.
		queue_store_word(0, 0, 1, 32'h8000_0001);
		queue_lookup(0, 0, 1, 32'h1000_0000);
		queue_lookup(0, 0, 0, 32'h1000_0000);
		// No access at all; the sender first lets the unit drain.
		queue_store_word(0, 0, 1, 32'h0000_0000, 1);
		queue_lookup(0, 0, 0, 32'h1000_0000);
		// Entry 1 overlaps entry 0 with the widest block: the lower entry wins.
		queue_store_word(0, 1, 0, 32'h1000_1FFF);
		queue_store_word(0, 1, 1, 32'h4560_0002);
		queue_lookup(0, 0, 0, 32'h1000_0000);
		queue_store_word(0, 0, 0, 32'h0000_0000);
		queue_lookup(1, 0, 1, 32'h1FFF_FFFF);
		// Instruction entry 3: top segment, all-ones lower word; is_write is ignored.
		queue_store_word(1, 3, 0, 32'hF000_1FFF);
		queue_store_word(1, 3, 1, 32'hFFFF_FFFF);
		queue_lookup(1, 1, 1, 32'hFFFF_FFFF);
		queue_lookup(0, 1, 0, 32'hF123_4567);
		queue_lookup(0, 0, 0, 32'hF123_4567);
		queue_store_word(1, 3, 1, 32'h0000_0000);
		queue_lookup(0, 1, 0, 32'hF000_0000);

		// Random part: mostly well-formed entries and addresses aimed at them.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			side = 1'($urandom_range(0, 1));
			e    = 2'($urandom_range(0, 3));
			if ($urandom_range(0, 99) < 15) begin
				if ($urandom_range(0, 1)) begin
					queue_store_word(side, e, 1, $urandom, n == 500 || n == 1300);
				end else if ($urandom_range(0, 9) == 0) begin
					queue_store_word(side, e, 0, $urandom, n == 500 || n == 1300);
				end else begin
					k  = $urandom_range(0, 11);
					bl = (((32'h1 << k) - 1) & 32'h7FF) << 2;
					up = ($urandom & SEG_MASK) | ($urandom & BEPI_MASK & ~(bl << BL_SHIFT)) |
						bl | ($urandom & 32'h0001_E000) |
						($urandom_range(0, 9) == 0 ? 32'h0 : $urandom_range(1, 3));
					queue_store_word(side, e, 0, up, n == 500 || n == 1300);
				end
			end else if ($urandom_range(0, 9) < 7) begin
				up = gen_upper[side][e];
				bl = (up & BL_MASK) << BL_SHIFT;
				va = (up & SEG_MASK) | (up & BEPI_MASK) | ($urandom & bl) |
					($urandom & 32'h0001_FFFF);
				if (up[1] && up[0])
					user = 1'($urandom_range(0, 1));
				else if (up[1] || up[0])
					user = ($urandom_range(0, 4) == 0) ? up[1] : up[0];
				else
					user = 1'($urandom_range(0, 1));
				queue_lookup(user, side, 1'($urandom_range(0, 1)), va,
					n == 500 || n == 1300);
			end else begin
				queue_lookup(1'($urandom_range(0, 1)), side, 1'($urandom_range(0, 1)),
					$urandom, n == 500 || n == 1300);
			end
		end
		total_items = pending_items.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		do @(posedge clk);
		while (accepted_cnt != total_items || received_cnt != total_items);
		repeat (8) @(posedge clk);
		if (error_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

[sim.f]
sv/bat_pkg.sv
sv/bat_front.sv
sv/bat_queue.sv
sv/bat_back.sv
sv/block_address_translation_unit.sv
tb/testbench.sv
